>>> hw/rtl/stack_expression_evaluator_assert.svh
// ----------------------------------------------------------------------------
// Stack expression evaluator assertion macros
// Shared concurrent assertion forms on clk_i with asynchronous reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef STACK_EXPRESSION_EVALUATOR_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define SEE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/see_pkg.sv
// ----------------------------------------------------------------------------
// see_pkg
// Types and constants of the stack expression evaluator.
// ----------------------------------------------------------------------------
package see_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [APB_AW-1:0] REG_PREFIX_MODE = 3'd0;

  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;
  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2b;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2d;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2a;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2f;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_INVALID   = 3'd4,
    ST_EMPTY     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/see_ram.sv
// ----------------------------------------------------------------------------
// see_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module see_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/see_div.sv
// ----------------------------------------------------------------------------
// see_div
// Radix-2 restoring signed divider, truncating toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module see_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [see_pkg::DATA_W-1:0] num_i,
  input  logic [see_pkg::DATA_W-1:0] den_i,
  output see_pkg::div_stat_t        stat_o,
  output logic [see_pkg::DATA_W-1:0] quo_o
);
  import see_pkg::*;

  logic [DATA_W-1:0]    rem_q, quo_q, den_q;
  logic                 neg_q;
  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DATA_W:0]      rem_shift, diff;
  logic                 ge;

  assign rem_shift = {rem_q, quo_q[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, den_q};
  assign ge        = !diff[DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[DATA_W-1] ? DATA_W'(0) - num_i : num_i;
      den_q <= den_i[DATA_W-1] ? DATA_W'(0) - den_i : den_i;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = neg_q ? DATA_W'(0) - quo_q : quo_q;

endmodule

>>> hw/rtl/stack_expression_evaluator.sv
// ----------------------------------------------------------------------------
// stack_expression_evaluator
// Postfix / prefix expression evaluator on an operand stack held in RAM.
// ----------------------------------------------------------------------------
//  port group  dir  payload
//  s_axis      in   tdata[7:0] symbol, tlast last_symbol
//  m_axis      out  tdata[31:0] value, tdata[34:32] status
//  apb         in   reg 0 prefix_mode at byte address 0
//
//  Digits, + - * and unknown symbols pass through accept, then execute.
//  '/' with a nonzero divisor then waits in a divide state for the radix-2 divider.
//  An item marked last then passes an emit state that loads the output register.
//  The output register stalls the block only when a second result is ready.
//  Reset clears stack pointer, status and prefix_mode; stack RAM is not cleared.
// ----------------------------------------------------------------------------
`include "stack_expression_evaluator_assert.svh"

module stack_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [see_pkg::SYM_W-1:0]      s_axis_tdata,  // [7:0] symbol
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [see_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // [31:0] value, [34:32] status
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [see_pkg::APB_AW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import see_pkg::*;

  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);

  state_e            state_q, state_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  status_e           err_q, err_d;
  logic [DATA_W-1:0] tos_q, tos_d;
  logic [SYM_W-1:0]  sym_q;
  logic              last_q;
  logic              prefix_mode_q;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;

  logic              accept;
  logic              is_digit, is_op;
  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic              ram_we;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] lhs, rhs;
  logic [DATA_W-1:0] mul_res;
  logic              div_start;
  div_stat_t         div_stat;
  logic [DATA_W-1:0] div_quo;
  logic              emit_load;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PREFIX_MODE) ? {31'b0, prefix_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_PREFIX_MODE) begin
      prefix_mode_q <= pwdata[0];
    end
  end

  // stack RAM holds entries below the top; top lives in tos_q
  assign sp_m1 = sp_q - SP_W'(1);
  assign sp_m2 = sp_q - SP_W'(2);

  see_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(sp_m1[AW-1:0]),
    .wdata_i(tos_q),
    .raddr_i(sp_m2[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign is_digit = (sym_q >= SYM_ZERO) && (sym_q <= SYM_NINE);
  assign is_op    = (sym_q == SYM_ADD) || (sym_q == SYM_SUB) ||
                    (sym_q == SYM_MUL) || (sym_q == SYM_DIV);
  assign lhs      = prefix_mode_q ? tos_q : ram_rdata;
  assign rhs      = prefix_mode_q ? ram_rdata : tos_q;
  assign mul_res  = lhs * rhs;

  see_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (lhs),
    .den_i  (rhs),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit_load     = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    err_d        = err_q;
    tos_d        = tos_q;
    ram_we       = 1'b0;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = last_q ? S_EMIT : S_IDLE;
        if (is_digit) begin
          if (sp_q == SP_W'(STACK_DEPTH)) begin
            if (err_q == ST_OK) err_d = ST_OVERFLOW;
          end else begin
            ram_we = (sp_q != '0);
            tos_d  = {{(DATA_W-SYM_W){1'b0}}, sym_q - SYM_ZERO};
            sp_d   = sp_q + SP_W'(1);
          end
        end else if (is_op) begin
          if (sp_q < SP_W'(2)) begin
            if (err_q == ST_OK) err_d = ST_UNDERFLOW;
          end else if (sym_q == SYM_DIV) begin
            if (rhs == '0) begin
              if (err_q == ST_OK) err_d = ST_DIVZERO;
              tos_d = '0;
              sp_d  = sp_m1;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end else begin
            case (sym_q)
              SYM_ADD: tos_d = lhs + rhs;
              SYM_SUB: tos_d = lhs - rhs;
              default: tos_d = mul_res;
            endcase
            sp_d = sp_m1;
          end
        end else begin
          if (err_q == ST_OK) err_d = ST_INVALID;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          tos_d   = div_quo;
          sp_d    = sp_m1;
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = (sp_q != '0) ? tos_q : '0;
          out_status_d = (err_q != ST_OK) ? err_q :
                         ((sp_q == '0) ? ST_EMPTY : ST_OK);
          sp_d         = '0;
          err_d        = ST_OK;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q        <= tos_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    if (accept) begin
      sym_q  <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-DATA_W-STATUS_W){1'b0}}, out_status_q, out_value_q};

  `SEE_ASSERT_IMP(a_sp_bound, 1'b1, sp_q <= SP_W'(STACK_DEPTH), "stack pointer out of range")
  `SEE_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `SEE_ASSERT_IMP(a_div_done_state, div_stat.done, state_q == S_DIV, "divider done outside wait")
  `SEE_ASSERT_NXT(a_emit_clears, emit_load, sp_q == '0 && err_q == ST_OK && out_valid_q,
                  "expression state not cleared after result")

endmodule

>>> tb/stack_expression_evaluator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_expression_evaluator_tb
// Feeds postfix and prefix expressions one symbol per item over the input
// stream and sets the operand order through the register port. A tracker
// keeps its own operand stack, works out the value and status for every
// item marked last, and compares them with the results on the output stream.
// ----------------------------------------------------------------------------
module stack_expression_evaluator_tb;
  import see_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [DATA_W-1:0] value;
    status_e           status;
  } answer_t;

  class eval_tracker;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       depth = 0;
    status_e           sticky = ST_OK;
    logic              prefix = 1'b0;
    answer_t           pending_answers [$];
    int unsigned       mismatch_count = 0;

    function void set_mode(logic m);
      prefix = m;
    endfunction

    function void raise(status_e code);
      if (sticky == ST_OK) sticky = code;
    endfunction

    function logic [DATA_W-1:0] trunc_quotient(logic [DATA_W-1:0] n, logic [DATA_W-1:0] d);
      logic [DATA_W-1:0] un, ud, q;
      un = n[DATA_W-1] ? -n : n;
      ud = d[DATA_W-1] ? -d : d;
      q  = un / ud;
      return (n[DATA_W-1] ^ d[DATA_W-1]) ? -q : q;
    endfunction

    function void apply_symbol(logic [SYM_W-1:0] sym, logic last);
      logic [DATA_W-1:0] lhs, rhs, res;
      answer_t ans;
      if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
        if (depth >= STACK_DEPTH) begin
          raise(ST_OVERFLOW);
        end else begin
          operands[depth] = DATA_W'(sym - SYM_ZERO);
          depth++;
        end
      end else if (sym == SYM_ADD || sym == SYM_SUB || sym == SYM_MUL || sym == SYM_DIV) begin
        if (depth < 2) begin
          raise(ST_UNDERFLOW);
        end else begin
          lhs = prefix ? operands[depth-1] : operands[depth-2];
          rhs = prefix ? operands[depth-2] : operands[depth-1];
          case (sym)
            SYM_ADD: res = lhs + rhs;
            SYM_SUB: res = lhs - rhs;
            SYM_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                raise(ST_DIVZERO);
                res = '0;
              end else begin
                res = trunc_quotient(lhs, rhs);
              end
            end
          endcase
          depth -= 2;
          operands[depth] = res;
          depth++;
        end
      end else begin
        raise(ST_INVALID);
      end
      if (last) begin
        ans.value  = (depth > 0) ? operands[depth-1] : '0;
        ans.status = sticky;
        if (depth == 0 && sticky == ST_OK) ans.status = ST_EMPTY;
        pending_answers.push_back(ans);
        depth  = 0;
        sticky = ST_OK;
      end
    endfunction

    function void compare_answer(logic [OUT_TDATA_W-1:0] tdata);
      answer_t ans;
      logic [DATA_W-1:0]   got_value;
      logic [STATUS_W-1:0] got_status;
      got_value  = tdata[DATA_W-1:0];
      got_status = tdata[DATA_W+STATUS_W-1:DATA_W];
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result value=%08h status=%0d", $realtime, got_value,
                   got_status);
        return;
      end
      ans = pending_answers.pop_front();
      if (got_value !== ans.value || got_status !== ans.status) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch exp value=%08h status=%0d, got value=%08h status=%0d",
                   $realtime, ans.value, ans.status, got_value, got_status);
      end
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [SYM_W-1:0]       s_axis_tdata;   // [7:0] symbol
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] value, [34:32] status
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_AW-1:0]      paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  stack_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  eval_tracker tracker = new;

  logic [SYM_W-1:0] sym_q [$];
  logic             last_q [$];
  bit               quiet_in;
  bit               quiet_out;
  bit               cur_mode;
  int unsigned      items_sent;
  int unsigned      cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (psel && penable && pwrite && pready && paddr == REG_PREFIX_MODE)
        tracker.set_mode(pwdata[0]);
      if (s_axis_tvalid && s_axis_tready)
        tracker.apply_symbol(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        tracker.compare_answer(m_axis_tdata);
    end
  end

  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // output side: random stalls, with quiet stretches
  initial begin
    int unsigned run, gap;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(7, 0) == 0) quiet_out = ~quiet_out;
      run = $urandom_range(8, 1);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap(quiet_out);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  task automatic put_symbol(input logic [SYM_W-1:0] sym, input logic last);
    int unsigned gap;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_expr(input bit counted);
    quiet_in = ($urandom_range(3, 0) == 0);
    foreach (sym_q[i]) put_symbol(sym_q[i], last_q[i]);
    if (counted) items_sent += sym_q.size();
  endtask

  task automatic write_mode(input logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PREFIX_MODE;
    pwdata  <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_mode = m;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [SYM_W-1:0] pick_op(bit mul_heavy);
    if (mul_heavy && $urandom_range(1, 0)) return SYM_MUL;
    case ($urandom_range(3, 0))
      0:       return SYM_ADD;
      1:       return SYM_SUB;
      2:       return SYM_MUL;
      default: return SYM_DIV;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] pick_digit();
    return SYM_ZERO + SYM_W'($urandom_range(9, 0));
  endfunction

  function automatic void add_sym(logic [SYM_W-1:0] s);
    sym_q.push_back(s);
    last_q.push_back(1'b0);
  endfunction

  function automatic void close_expr();
    last_q[last_q.size()-1] = 1'b1;
  endfunction

  // well-formed expression, random shape, optionally with a stray symbol
  function automatic void build_formed();
    int unsigned len, max_depth, depth, n, pos;
    bit mul_heavy;
    len       = $urandom_range(12, 1);
    max_depth = $urandom_range(8, 2);
    mul_heavy = ($urandom_range(9, 0) < 3);
    depth     = 0;
    n         = 0;
    while (!(depth == 1 && n >= len)) begin
      if (depth < 2 || (depth < max_depth && n < len && $urandom_range(1, 0))) begin
        add_sym(pick_digit());
        depth++;
      end else begin
        add_sym(pick_op(mul_heavy));
        depth--;
      end
      n++;
    end
    if ($urandom_range(99, 0) < 15) begin
      pos = $urandom_range(sym_q.size(), 0);
      sym_q.insert(pos, $urandom_range(1, 0) ? pick_op(1'b0) : 8'($urandom_range(255, 0)));
      last_q.insert(pos, 1'b0);
    end
    close_expr();
  endfunction

  // push up to or past the stack limit, then fold everything back down
  function automatic void build_deep();
    int unsigned k;
    k = $urandom_range(STACK_DEPTH + 4, STACK_DEPTH - 2);
    repeat (k) add_sym(pick_digit());
    repeat (k - 1) add_sym(pick_op(1'b0));
    close_expr();
  endfunction

  // most negative value, usually divided by minus one, operand order per mode
  function automatic void build_wrap();
    if (cur_mode) begin
      add_sym(SYM_ZERO + 8'd1); add_sym(SYM_ZERO); add_sym(SYM_SUB);
    end
    add_sym(SYM_ZERO + 8'd2);
    repeat (10) begin
      add_sym(SYM_ZERO + 8'd8);
      add_sym(SYM_MUL);
    end
    if (!cur_mode) begin
      add_sym(SYM_ZERO); add_sym(SYM_ZERO + 8'd1); add_sym(SYM_SUB);
    end
    if ($urandom_range(3, 0) != 0) add_sym(SYM_DIV);
    close_expr();
  endfunction

  function automatic void build_noise();
    int unsigned len;
    len = $urandom_range(8, 1);
    repeat (len) begin
      if ($urandom_range(1, 0)) add_sym(8'($urandom_range(255, 0)));
      else if ($urandom_range(1, 0)) add_sym(pick_digit());
      else add_sym(pick_op(1'b0));
      last_q[last_q.size()-1] = ($urandom_range(3, 0) == 0);
    end
    close_expr();
  endfunction

  task automatic send_text(input string text);
    sym_q.delete();
    last_q.delete();
    foreach (text[i]) add_sym(text[i]);
    close_expr();
    send_expr(1'b0);
  endtask

  initial begin
    int unsigned r, budget;
    bit counted;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cur_mode      = 1'b0;
    items_sent    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all operators, divide by zero, negative truncation,
    // underflow, and symbols at both ends of the byte range
    send_text("34+2*");
    send_text("92-3/");
    send_text("50/");
    send_text("07-2/");
    send_text("+");
    sym_q.delete();
    last_q.delete();
    add_sym(8'h00);
    add_sym(SYM_NINE);
    add_sym(8'hff);
    close_expr();
    send_expr(1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_mode(p[0] ? 1'b0 : 1'b1);
      budget = items_sent + ITEM_TARGET / PHASES;
      while (items_sent < budget) begin
        sym_q.delete();
        last_q.delete();
        r = $urandom_range(99, 0);
        counted = 1'b1;
        if (r < 3) build_deep();
        else if (r < 8) build_wrap();
        else if (r < 25) begin
          build_noise();
          counted = 1'b0;
        end else build_formed();
        send_expr(counted);
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
